FILE: sv/calibration_table_interpolator_defines.svh
// ----------------------------------------------------------------------------
// Calibration table interpolator assertion macros
// Concurrent property shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef CALIBRATION_TABLE_INTERPOLATOR_DEFINES_SVH
`define CALIBRATION_TABLE_INTERPOLATOR_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define CTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cti checker: next-cycle property failed");

// Consequent must hold in the same cycle as the antecedent.
`define CTI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cti checker: same-cycle property failed");

`endif

FILE: sv/cti_pkg.sv
// ----------------------------------------------------------------------------
// Calibration table interpolator package
// Table sizing, field widths, command codes and the table entry type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cti_pkg;

  localparam int MAX_POINTS = 16;
  localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int CMD_W   = 1;
  localparam int INDEX_W = 4;
  localparam int DATA_W  = 16;
  localparam int VP_W    = 5;
  localparam int STEP_W  = $clog2(DATA_W);

  localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] view;
    logic [DATA_W-1:0] hor;
    logic [DATA_W-1:0] ver;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: sv/cti_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/calibration_table_interpolator.sv
// A table write is taken and gives no result. A query holds in_stall through the clamp
// checks, a serial scan of breakpoint pairs (up to MAX_POINTS-1), a multiply and a
// 16-step restoring divide for each axis, and the load of the output register. With no
// points, or when clamped, it goes straight to the output load. It holds longer while
// out_stall holds a waiting result. One query at a time.
// Reset is synchronous, active low: clears valid_points and control; table undefined.
// ----------------------------------------------------------------------------
// Calibration table interpolator
// Piecewise-linear lookup of horizontal and vertical lens corrections from a
// breakpoint table, with a serial breakpoint search and a shared divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module calibration_table_interpolator import cti_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [VP_W-1:0]    cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [INDEX_W-1:0] in_entry_index,
  input  logic [DATA_W-1:0]  in_view_value,
  input  logic [DATA_W-1:0]  in_hor_value,
  input  logic [DATA_W-1:0]  in_ver_value,
  input  logic [DATA_W-1:0]  in_lens_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DATA_W-1:0]  out_hor_axis,
  output logic [DATA_W-1:0]  out_ver_axis
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADDR0,
    ST_CHK0,
    ST_CHKL,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_ACC,
    ST_FIN
  } state_t;

  state_t              state_r;
  logic [VP_W-1:0]     valid_points_r;
  logic [ADDR_W-1:0]   rd_addr_r;
  logic [ADDR_W-1:0]   last_idx_r;
  logic [ADDR_W-1:0]   lo_idx_r;
  logic [DATA_W-1:0]   angle_r;
  entry_t              hi_r;
  entry_t              lo_r;
  entry_t              last_r;
  logic [DATA_W-1:0]   den_r;
  logic [DATA_W-1:0]   dist_r;
  logic [DATA_W-1:0]   rem_r;
  logic [DATA_W-1:0]   dvd_r;
  logic [STEP_W-1:0]   step_r;
  logic                neg_r;
  logic                axis_r;
  logic [DATA_W-1:0]   res_hor_r;
  logic [DATA_W-1:0]   res_ver_r;
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_hor_r;
  logic [DATA_W-1:0]   out_ver_r;

  logic                in_xfer;
  logic                ram_wr_en;
  entry_t              ram_wr_entry;
  logic [ENTRY_W-1:0]  ram_rd_data;
  entry_t              rd_entry;
  logic [CNT_W-1:0]    used_points;
  logic                match;
  logic [DATA_W-1:0]   pair_den;
  logic [DATA_W-1:0]   c_hi;
  logic [DATA_W-1:0]   c_lo;
  logic                c_neg;
  logic [DATA_W-1:0]   c_mag;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W:0]     div_trial;
  logic [DATA_W:0]     div_diff;
  logic                div_ge;
  logic [DATA_W-1:0]   acc_val;
  logic                out_free;

  assign in_stall     = (state_r != ST_IDLE);
  assign in_xfer      = in_valid && !in_stall;
  assign out_valid    = out_valid_r;
  assign out_hor_axis = out_hor_r;
  assign out_ver_axis = out_ver_r;
  assign out_free     = !out_valid_r || !out_stall;

  assign ram_wr_en    = in_xfer && (in_command == CMD_WRITE) &&
                        (32'(in_entry_index) < MAX_POINTS);
  assign ram_wr_entry = '{view: in_view_value, hor: in_hor_value, ver: in_ver_value};
  assign rd_entry     = entry_t'(ram_rd_data);

  cti_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ADDR_W'(in_entry_index)),
    .wr_data (ram_wr_entry),
    .rd_addr (rd_addr_r),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    if (32'(valid_points_r) > MAX_POINTS) begin
      used_points = CNT_W'(MAX_POINTS);
    end else begin
      used_points = CNT_W'(valid_points_r);
    end
  end

  assign match    = (angle_r >= rd_entry.view) && (angle_r <= hi_r.view);
  assign pair_den = hi_r.view - rd_entry.view;

  assign c_hi  = axis_r ? hi_r.ver : hi_r.hor;
  assign c_lo  = axis_r ? lo_r.ver : lo_r.hor;
  assign c_neg = (c_lo < c_hi);
  assign c_mag = c_neg ? (c_hi - c_lo) : (c_lo - c_hi);
  assign prod  = dist_r * c_mag;

  assign div_trial = {rem_r, dvd_r[DATA_W-1]};
  assign div_diff  = div_trial - {1'b0, den_r};
  assign div_ge    = (div_trial >= {1'b0, den_r});

  assign acc_val = neg_r ? (c_hi - dvd_r) : (c_hi + dvd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      valid_points_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        valid_points_r <= cfg_wr_data;
      end
      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_xfer && (in_command == CMD_QUERY)) begin
            angle_r    <= in_lens_angle;
            rd_addr_r  <= '0;
            last_idx_r <= ADDR_W'(used_points - CNT_W'(1));
            if (used_points == '0) begin
              res_hor_r <= '0;
              res_ver_r <= '0;
              state_r   <= ST_FIN;
            end else begin
              state_r <= ST_ADDR0;
            end
          end
        end

        ST_ADDR0: begin
          rd_addr_r <= last_idx_r;
          state_r   <= ST_CHK0;
        end

        ST_CHK0: begin
          hi_r      <= rd_entry;
          rd_addr_r <= ADDR_W'(1);
          if (angle_r >= rd_entry.view) begin
            res_hor_r <= rd_entry.hor;
            res_ver_r <= rd_entry.ver;
            state_r   <= ST_FIN;
          end else begin
            state_r <= ST_CHKL;
          end
        end

        ST_CHKL: begin
          last_r    <= rd_entry;
          rd_addr_r <= rd_addr_r + ADDR_W'(1);
          lo_idx_r  <= ADDR_W'(1);
          if (angle_r <= rd_entry.view) begin
            res_hor_r <= rd_entry.hor;
            res_ver_r <= rd_entry.ver;
            state_r   <= ST_FIN;
          end else begin
            state_r <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          rd_addr_r <= rd_addr_r + ADDR_W'(1);
          lo_idx_r  <= lo_idx_r + ADDR_W'(1);
          if (match) begin
            lo_r   <= rd_entry;
            den_r  <= pair_den;
            dist_r <= hi_r.view - angle_r;
            axis_r <= 1'b0;
            if (pair_den == '0) begin
              res_hor_r <= hi_r.hor;
              res_ver_r <= hi_r.ver;
              state_r   <= ST_FIN;
            end else begin
              state_r <= ST_MUL;
            end
          end else begin
            hi_r <= rd_entry;
            if (lo_idx_r == last_idx_r) begin
              res_hor_r <= last_r.hor;
              res_ver_r <= last_r.ver;
              state_r   <= ST_FIN;
            end
          end
        end

        ST_MUL: begin
          rem_r   <= prod[2*DATA_W-1:DATA_W];
          dvd_r   <= prod[DATA_W-1:0];
          neg_r   <= c_neg;
          step_r  <= '0;
          state_r <= ST_DIV;
        end

        ST_DIV: begin
          rem_r  <= div_ge ? div_diff[DATA_W-1:0] : div_trial[DATA_W-1:0];
          dvd_r  <= {dvd_r[DATA_W-2:0], div_ge};
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(DATA_W - 1)) begin
            state_r <= ST_ACC;
          end
        end

        ST_ACC: begin
          if (axis_r) begin
            res_ver_r <= acc_val;
            state_r   <= ST_FIN;
          end else begin
            res_hor_r <= acc_val;
            axis_r    <= 1'b1;
            state_r   <= ST_MUL;
          end
        end

        ST_FIN: begin
          if (out_free) begin
            out_hor_r <= res_hor_r;
            out_ver_r <= res_ver_r;
            state_r   <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/cti_checker.sv
// ----------------------------------------------------------------------------
// Calibration table interpolator checker
// Port-level properties of the query sequencer and the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "calibration_table_interpolator_defines.svh"

module cti_checker import cti_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [CMD_W-1:0]   in_command,
  input logic               out_valid,
  input logic               out_stall,
  input logic [DATA_W-1:0]  out_hor_axis,
  input logic [DATA_W-1:0]  out_ver_axis
);

  logic                in_xfer;
  logic                query_xfer;
  logic                write_xfer;
  logic                out_held;
  logic [2*DATA_W-1:0] out_pair;

  assign in_xfer    = in_valid && !in_stall;
  assign query_xfer = in_xfer && (in_command == CMD_QUERY);
  assign write_xfer = in_xfer && (in_command == CMD_WRITE);
  assign out_held   = out_valid && out_stall;
  assign out_pair   = {out_hor_axis, out_ver_axis};

  `CTI_ASSERT_NEXT(a_query_holds_input, clk, rst_n, query_xfer, in_stall)
  `CTI_ASSERT_NEXT(a_write_keeps_ready, clk, rst_n, write_xfer, !in_stall)
  `CTI_ASSERT_SAME(a_result_ends_query, clk, rst_n, $rose(out_valid), $past(in_stall))
  `CTI_ASSERT_NEXT(a_result_holds, clk, rst_n, out_held, out_valid && $stable(out_pair))

endmodule

bind calibration_table_interpolator cti_checker u_cti_checker (.*);
